// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lgps_pkg.sv
// ----------------------------------------------------------------------------
// Linear gradient pad shader package
// Shared constants, transaction types and the packed two-lane color blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lgps_pkg;

  // Ramp table geometry.
  localparam int unsigned RAMP_DEPTH = 256;
  localparam int unsigned RAMP_AW    = $clog2(RAMP_DEPTH);

  // Configuration register index width.
  localparam int unsigned CFG_IDX_W = 3;

  // Half a pixel in 16.16 fixed point.
  localparam logic [31:0] POS_HALF = 32'h0000_8000;

  // Lane masks for the packed blend.
  localparam logic [31:0] LO_LANES = 32'h00ff_00ff;
  localparam logic [31:0] HI_LANES = 32'hff00_ff00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_X       = 3'd0,
    CFG_DIR_Y       = 3'd1,
    CFG_START_X     = 3'd2,
    CFG_START_Y     = 3'd3,
    CFG_RAMP_LENGTH = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_SHADE = 1'b1
  } func_e;

  typedef logic [RAMP_AW-1:0] ramp_addr_t;

  typedef struct packed {
    func_e              func;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               span_end;
    logic [7:0]         entry_index;
    logic [31:0]        entry_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic        span_last;
  } out_item_t;

  // Ramp RAM write and read requests.
  typedef struct packed {
    logic        en;
    ramp_addr_t  addr;
    logic [31:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic       en;
    ramp_addr_t addr0;
    logic       [RAMP_AW-1:0] addr1;
  } ram_rd_t;

  // Packed blend of two ARGB8888 colors, weight 1..256 toward c0.
  function automatic logic [31:0] interp256(logic [8:0] w, logic [31:0] c0,
                                            logic [31:0] c1);
    logic [31:0] ag_diff;
    logic [31:0] rb_diff;
    logic [31:0] ag_prod;
    logic [31:0] rb_prod;
    logic [31:0] ag;
    logic [31:0] rb;
    ag_diff = ((c0 >> 8) & LO_LANES) - ((c1 >> 8) & LO_LANES);
    rb_diff = (c0 & LO_LANES) - (c1 & LO_LANES);
    ag_prod = ag_diff * 32'(w);
    rb_prod = rb_diff * 32'(w);
    ag      = (ag_prod + (c1 & HI_LANES)) & HI_LANES;
    rb      = ((rb_prod >> 8) + (c1 & LO_LANES)) & LO_LANES;
    return ag + rb;
  endfunction

endpackage

// File: rtl/core/lgps_ramp_ram.sv
// ----------------------------------------------------------------------------
// Color ramp RAM
// One write port and two registered read ports over the ramp table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgps_ramp_ram (
  input  logic              clk_i,
  input  lgps_pkg::ram_wr_t wr_i,
  input  lgps_pkg::ram_rd_t rd_i,
  output logic [31:0]       rd_data0_o,
  output logic [31:0]       rd_data1_o
);
  import lgps_pkg::*;

  logic [31:0] mem_q [RAMP_DEPTH];
  logic [31:0] rd_data0_q;
  logic [31:0] rd_data1_q;

  // Table write.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Both reads hold their data until the next enabled read.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data0_q <= mem_q[rd_i.addr0];
      rd_data1_q <= mem_q[rd_i.addr1];
    end
  end

  assign rd_data0_o = rd_data0_q;
  assign rd_data1_o = rd_data1_q;

endmodule

// File: rtl/core/linear_gradient_pad_shader_top.sv
// ----------------------------------------------------------------------------
// Linear gradient pad shader
// Shades pixels of a linear gradient with pad spread from a loadable ramp.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Carries
//   in        input      in_valid_i/in_ready_o  ramp write or pixel to shade
//   out       output     out_valid_o/out_ready_i shaded pixel and span marker
//   cfg       input      cfg_we_i               register index and data
//
// One transaction enters per cycle while the pipeline has room; a shaded
// pixel leaves through the five-stage pipeline: offset, two 32x32 multipliers,
// position and addressing, one two-port ramp RAM read, then the blend.
// Ramp writes travel the stages up to the RAM and write it in order with reads.
// Reset clears the configuration registers and empties the pipeline;
// the ramp contents are not cleared and must be loaded before use.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and an item is taken while a result waits at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module linear_gradient_pad_shader_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [lgps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [31:0]                        cfg_wdata_i,
  // Input transactions.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lgps_pkg::in_item_t                 in_item_i,
  // Output transactions.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lgps_pkg::out_item_t                out_item_o
);
  import lgps_pkg::*;

  typedef struct packed {
    func_e              func;
    logic               span;
    logic               wr_ok;
    ramp_addr_t         wr_addr;
    logic [31:0]        wr_data;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
  } s1_t;

  typedef struct packed {
    func_e       func;
    logic        span;
    logic        wr_ok;
    ramp_addr_t  wr_addr;
    logic [31:0] wr_data;
    logic [31:0] mx;
    logic [31:0] my;
  } s2_t;

  typedef struct packed {
    func_e       func;
    logic        span;
    logic        wr_ok;
    ramp_addr_t  wr_addr;
    logic [31:0] wr_data;
    ramp_addr_t  addr0;
    ramp_addr_t  addr1;
    logic [8:0]  weight;
  } s3_t;

  typedef struct packed {
    logic       span;
    logic [8:0] weight;
  } s4_t;

  // Configuration registers.
  logic signed [31:0] dir_x_q, dir_y_q;
  logic [31:0]        start_x_q, start_y_q;
  ramp_addr_t         len_m1_q, len_m1_d;
  logic [8:0]         len_raw;

  // Pipeline registers.
  logic      s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  s1_t       s1_q, s1_d;
  s2_t       s2_q, s2_d;
  s3_t       s3_q, s3_d;
  s4_t       s4_q, s4_d;
  out_item_t s5_q, s5_d;
  logic      ready1, ready2, ready3, ready4, ready5;

  logic signed [63:0] prod_x, prod_y;
  logic [31:0]        pos;
  logic [14:0]        pos_idx;
  ram_wr_t            ram_wr;
  ram_rd_t            ram_rd;
  logic [31:0]        rd_data0, rd_data1;

  // Ramp length minus one, saturated to the table depth.
  always_comb begin
    len_raw = cfg_wdata_i[8:0];
    if (len_raw == 9'd0) begin
      len_m1_d = '0;
    end else if (32'(len_raw) > RAMP_DEPTH) begin
      len_m1_d = RAMP_AW'(RAMP_DEPTH - 1);
    end else begin
      len_m1_d = RAMP_AW'(len_raw - 9'd1);
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q   <= '0;
      dir_y_q   <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      len_m1_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIR_X:       dir_x_q   <= cfg_wdata_i;
        CFG_DIR_Y:       dir_y_q   <= cfg_wdata_i;
        CFG_START_X:     start_x_q <= cfg_wdata_i;
        CFG_START_Y:     start_y_q <= cfg_wdata_i;
        CFG_RAMP_LENGTH: len_m1_q  <= len_m1_d;
        default: ;
      endcase
    end
  end

  // Stage readiness: a stage moves when the next one is empty or moving.
  assign ready5     = !s5_valid_q || out_ready_i;
  assign ready4     = !s4_valid_q || ready5;
  assign ready3     = !s3_valid_q || ready4;
  assign ready2     = !s2_valid_q || ready3;
  assign ready1     = !s1_valid_q || ready2;
  assign in_ready_o = ready1;

  // Stage 1: pixel offsets from the start point, plus write payload.
  always_comb begin
    s1_d.func    = in_item_i.func;
    s1_d.span    = in_item_i.span_end;
    s1_d.wr_ok   = 32'(in_item_i.entry_index) < RAMP_DEPTH;
    s1_d.wr_addr = RAMP_AW'(in_item_i.entry_index);
    s1_d.wr_data = in_item_i.entry_color;
    s1_d.fx      = {in_item_i.pixel_x, 16'h0000} - start_x_q + POS_HALF;
    s1_d.fy      = {in_item_i.pixel_y, 16'h0000} - start_y_q + POS_HALF;
  end

  // Stage 2: two 16.16 products, floor-shifted by 16.
  assign prod_x = dir_x_q * s1_q.fx;
  assign prod_y = dir_y_q * s1_q.fy;

  always_comb begin
    s2_d.func    = s1_q.func;
    s2_d.span    = s1_q.span;
    s2_d.wr_ok   = s1_q.wr_ok;
    s2_d.wr_addr = s1_q.wr_addr;
    s2_d.wr_data = s1_q.wr_data;
    s2_d.mx      = prod_x[47:16];
    s2_d.my      = prod_y[47:16];
  end

  // Stage 3: ramp position, pad clamping and neighbor addresses.
  // A clamped pixel reads one entry twice, which makes the blend a copy.
  assign pos     = s2_q.mx + s2_q.my - POS_HALF;
  assign pos_idx = pos[30:16];

  always_comb begin
    s3_d.func    = s2_q.func;
    s3_d.span    = s2_q.span;
    s3_d.wr_ok   = s2_q.wr_ok;
    s3_d.wr_addr = s2_q.wr_addr;
    s3_d.wr_data = s2_q.wr_data;
    s3_d.weight  = {1'b0, pos[15:8]} + 9'd1;
    if (pos[31]) begin
      s3_d.addr0 = '0;
      s3_d.addr1 = '0;
    end else if (32'(pos_idx) >= 32'(len_m1_q)) begin
      s3_d.addr0 = len_m1_q;
      s3_d.addr1 = len_m1_q;
    end else begin
      s3_d.addr1 = RAMP_AW'(pos_idx);
      s3_d.addr0 = RAMP_AW'(pos_idx) + RAMP_AW'(1);
    end
  end

  // Ramp RAM: writes and reads both happen as the item leaves stage 3.
  always_comb begin
    ram_wr.en    = s3_valid_q && (s3_q.func == FUNC_WRITE) && s3_q.wr_ok && ready4;
    ram_wr.addr  = s3_q.wr_addr;
    ram_wr.data  = s3_q.wr_data;
    ram_rd.en    = s3_valid_q && (s3_q.func == FUNC_SHADE) && ready4;
    ram_rd.addr0 = s3_q.addr0;
    ram_rd.addr1 = s3_q.addr1;
  end

  lgps_ramp_ram u_ramp_ram (
    .clk_i      (clk_i),
    .wr_i       (ram_wr),
    .rd_i       (ram_rd),
    .rd_data0_o (rd_data0),
    .rd_data1_o (rd_data1)
  );

  // Stage 4 carries the blend weight beside the RAM read data.
  always_comb begin
    s4_d.span   = s3_q.span;
    s4_d.weight = s3_q.weight;
  end

  // Stage 5: packed blend into the output register.
  always_comb begin
    s5_d.pixel_color = interp256(s4_q.weight, rd_data0, rd_data1);
    s5_d.span_last   = s4_q.span;
  end

  // Valid bits; write transactions drop out after stage 3.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (ready1) begin
        s1_valid_q <= in_valid_i;
      end
      if (ready2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (ready3) begin
        s3_valid_q <= s2_valid_q;
      end
      if (ready4) begin
        s4_valid_q <= s3_valid_q && (s3_q.func == FUNC_SHADE);
      end
      if (ready5) begin
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  // Payload registers load only when a valid item moves in.
  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (ready2 && s1_valid_q) begin
      s2_q <= s2_d;
    end
    if (ready3 && s2_valid_q) begin
      s3_q <= s3_d;
    end
    if (ready4 && s3_valid_q) begin
      s4_q <= s4_d;
    end
    if (ready5 && s4_valid_q) begin
      s5_q <= s5_d;
    end
  end

  assign out_valid_o = s5_valid_q;
  assign out_item_o  = s5_q;

  // An empty output stage never blocks the input.
  `ASSERT_IMPL(a_empty_out_ready, !s5_valid_q, in_ready_o,
               "input stalled while the output stage is empty")

  // Shading reads stay within the programmed ramp length.
  `ASSERT_IMPL(a_addr_in_len, s3_valid_q && (s3_q.func == FUNC_SHADE),
               (s3_q.addr0 <= len_m1_q) && (s3_q.addr1 <= len_m1_q),
               "ramp read address beyond the ramp length")

  // The two read addresses are equal or neighbors.
  `ASSERT_IMPL(a_addr_pair, s3_valid_q && (s3_q.func == FUNC_SHADE),
               (s3_q.addr0 == s3_q.addr1) ||
               (s3_q.addr0 == RAMP_AW'(s3_q.addr1 + RAMP_AW'(1))),
               "ramp read addresses are not neighbors")

  // A ramp write leaving stage 3 produces no result.
  `ASSERT_NEXT(a_write_no_result,
               s3_valid_q && (s3_q.func == FUNC_WRITE) && ready4, !s4_valid_q,
               "ramp write produced a result")

endmodule

// File: test/linear_gradient_pad_shader_top_tb.sv
// ----------------------------------------------------------------------------
// Linear gradient pad shader testbench
// Loads the color ramp and shades pixels under a series of gradient settings:
// a directed pass over the pad edges, the register extremes and the length
// saturation, then random spans around a window. A built-in predictor works
// out every shaded pixel and the monitor checks each output transaction in
// order. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_gradient_pad_shader_top_tb;

  import lgps_pkg::*;

  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 85;
  localparam int unsigned CALM_PHASE    = 4;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned HOLD_BACKLOG  = 32;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Predictor state: gradient registers and the ramp contents.
  logic [31:0] grad_dir_x   = '0;
  logic [31:0] grad_dir_y   = '0;
  logic [31:0] grad_start_x = '0;
  logic [31:0] grad_start_y = '0;
  logic [8:0]  ramp_len     = 9'd1;
  logic [31:0] ramp_colors [RAMP_DEPTH];

  // Transactions waiting to be offered and shaded pixels still due.
  in_item_t  queued_items [$];
  out_item_t pixels_due [$];

  int unsigned idle_pct       = 18;
  int unsigned results_seen   = 0;
  int unsigned hold_left      = 0;
  bit          long_hold_done = 1'b0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  // Pixel window that random spans are drawn around.
  logic [15:0] win_x = '0;
  logic [15:0] win_y = '0;

  linear_gradient_pad_shader_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // 16.16 product: full signed 64-bit multiply, floor shift by 16, low word.
  function automatic logic [31:0] fixed_mul(logic [31:0] a, logic [31:0] b);
    longint prod;
    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
    return prod[47:16];
  endfunction

  // Two-lane blend of neighbor entries, weight 1..256 toward the upper one.
  function automatic logic [31:0] blend_colors(logic [31:0] w, logic [31:0] upper,
                                               logic [31:0] lower);
    logic [31:0] ag;
    logic [31:0] rb;
    ag = ((((upper >> 8) & LO_LANES) - ((lower >> 8) & LO_LANES)) * w
          + (lower & HI_LANES)) & HI_LANES;
    rb = (((((upper & LO_LANES) - (lower & LO_LANES)) * w) >> 8)
          + (lower & LO_LANES)) & LO_LANES;
    return ag + rb;
  endfunction

  // Color of one pixel under the current gradient and ramp.
  function automatic logic [31:0] shade_pixel(logic [15:0] px, logic [15:0] py);
    logic [31:0] fx;
    logic [31:0] fy;
    logic [31:0] pos;
    logic [31:0] w;
    int unsigned len;
    int unsigned idx;
    len = (ramp_len == 0) ? 1 : (ramp_len > RAMP_DEPTH) ? RAMP_DEPTH : ramp_len;
    fx  = {px, 16'h0000} - grad_start_x + POS_HALF;
    fy  = {py, 16'h0000} - grad_start_y + POS_HALF;
    pos = fixed_mul(grad_dir_x, fx) + fixed_mul(grad_dir_y, fy) - POS_HALF;
    if (pos[31]) return ramp_colors[0];
    idx = pos[31:16];
    if (idx >= len - 1) return ramp_colors[len - 1];
    w = 32'(pos[15:8]) + 32'd1;
    return blend_colors(w, ramp_colors[idx + 1], ramp_colors[idx]);
  endfunction

  function automatic in_item_t ramp_write(logic [7:0] idx, logic [31:0] color);
    in_item_t item;
    item.func        = FUNC_WRITE;
    item.pixel_x     = 16'($urandom);
    item.pixel_y     = 16'($urandom);
    item.span_end    = 1'($urandom);
    item.entry_index = idx;
    item.entry_color = color;
    return item;
  endfunction

  function automatic in_item_t pixel_shade(logic [15:0] x, logic [15:0] y,
                                           logic last);
    in_item_t item;
    item.func        = FUNC_SHADE;
    item.pixel_x     = x;
    item.pixel_y     = y;
    item.span_end    = last;
    item.entry_index = 8'($urandom);
    item.entry_color = $urandom;
    return item;
  endfunction

  // Register write on the configuration port, mirrored into the predictor.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_DIR_X:       grad_dir_x   = value;
      CFG_DIR_Y:       grad_dir_y   = value;
      CFG_START_X:     grad_start_x = value;
      CFG_START_Y:     grad_start_y = value;
      CFG_RAMP_LENGTH: ramp_len     = value[8:0];
      default: ;
    endcase
  endtask

  task automatic set_gradient(logic [31:0] dx, logic [31:0] dy, logic [31:0] sx,
                              logic [31:0] sy, logic [31:0] len);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_RAMP_LENGTH, len);
    @(negedge clk_i);
  endtask

  // Wait until every transaction is in and every pixel is out, then let the
  // pipeline run dry, since ramp writes leave no output to wait for.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_items.size() != 0 || in_valid_i || pixels_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Random gradient: mostly a ramp from a random window that takes at least 32
  // pixels along each axis to cross, sometimes fully random registers.
  task automatic random_gradient();
    logic [31:0] dx;
    logic [31:0] dy;
    int unsigned len;
    int unsigned reach;
    win_x = 16'($urandom);
    win_y = 16'($urandom);
    if ($urandom_range(4) == 0) begin
      set_gradient($urandom, $urandom, $urandom, $urandom, $urandom_range(511));
    end else begin
      len   = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 256);
      reach = (len << 16) / 32;
      dx    = $urandom_range(reach);
      dy    = $urandom_range(reach);
      if ($urandom_range(1)) dx = -dx;
      if ($urandom_range(1)) dy = -dy;
      set_gradient(dx, dy, {win_x, 16'($urandom)}, {win_y, 16'($urandom)}, len);
    end
  endtask

  // Random phase: spans of consecutive pixels inside the window, with ramp
  // rewrites and stray pixels anywhere mixed in.
  task automatic random_phase();
    int unsigned made;
    int unsigned run;
    logic [15:0] x0;
    logic [15:0] y0;
    made = 0;
    while (made < PHASE_ITEMS) begin
      if ($urandom_range(99) < 12) begin
        queued_items.push_back(ramp_write(8'($urandom), $urandom));
        made++;
      end else if ($urandom_range(99) < 8) begin
        queued_items.push_back(pixel_shade(16'($urandom), 16'($urandom), 1'($urandom)));
        made++;
      end else begin
        run = $urandom_range(1, 16);
        x0  = win_x + 16'($urandom_range(127)) - 16'd64;
        y0  = win_y + 16'($urandom_range(127)) - 16'd64;
        for (int unsigned k = 0; k < run; k++)
          queued_items.push_back(pixel_shade(x0 + 16'(k), y0, k == run - 1));
        made += run;
      end
    end
  endtask

  // Main sequence: reset, directed phases, random phases, final check.
  initial begin
    foreach (ramp_colors[i]) ramp_colors[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // One entry per pixel with the top fraction byte full, whole ramp loaded.
    set_gradient(32'h0001_0000, 32'h0, 32'hffff_0100, 32'h0, 32'd256);
    for (int unsigned i = 0; i < RAMP_DEPTH; i++) begin
      case (i % 4)
        0:       queued_items.push_back(ramp_write(8'(i), 32'h0000_0000));
        1:       queued_items.push_back(ramp_write(8'(i), 32'hffff_ffff));
        default: queued_items.push_back(ramp_write(8'(i), $urandom));
      endcase
    end
    // Pad below, first blend, interior, last blend, pad above.
    queued_items.push_back(pixel_shade(16'h8000, 16'h8000, 1'b0));
    queued_items.push_back(pixel_shade(16'hffff, 16'h7fff, 1'b1));
    queued_items.push_back(pixel_shade(16'd0, 16'h0000, 1'b0));
    queued_items.push_back(pixel_shade(16'd1, 16'h8000, 1'b1));
    queued_items.push_back(pixel_shade(16'd127, 16'h7fff, 1'b0));
    queued_items.push_back(pixel_shade(16'd254, 16'h0000, 1'b1));
    queued_items.push_back(pixel_shade(16'd255, 16'h8000, 1'b0));
    queued_items.push_back(pixel_shade(16'h7fff, 16'h7fff, 1'b1));
    // A rewritten entry is read right behind its write.
    queued_items.push_back(ramp_write(8'd1, 32'h80ff_0080));
    queued_items.push_back(pixel_shade(16'd0, 16'd0, 1'b0));
    queued_items.push_back(pixel_shade(16'd1, 16'd0, 1'b1));
    wait_drained();

    // Register extremes with a one-entry ramp.
    set_gradient(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd1);
    queued_items.push_back(pixel_shade(16'h8000, 16'h7fff, 1'b0));
    queued_items.push_back(pixel_shade(16'h7fff, 16'h8000, 1'b0));
    queued_items.push_back(pixel_shade(16'h0000, 16'h0000, 1'b1));
    wait_drained();

    // A length of zero behaves as a length of one.
    set_gradient(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'd0);
    queued_items.push_back(pixel_shade(16'h8000, 16'h8000, 1'b0));
    queued_items.push_back(pixel_shade(16'h7fff, 16'h7fff, 1'b0));
    queued_items.push_back(pixel_shade(16'h0001, 16'hffff, 1'b1));
    wait_drained();

    // A length past the table saturates to the full table.
    set_gradient(32'h0000_8000, 32'h0000_4000, 32'h0, 32'h0, 32'd511);
    queued_items.push_back(pixel_shade(16'd300, 16'd200, 1'b0));
    queued_items.push_back(pixel_shade(16'd500, 16'd100, 1'b0));
    queued_items.push_back(pixel_shade(16'd600, 16'd700, 1'b1));
    wait_drained();

    // Two-entry ramp with half-pixel start: pad, blend and pad.
    set_gradient(32'h0001_0000, 32'h0, 32'h0000_8000, 32'h0, 32'd2);
    queued_items.push_back(pixel_shade(16'hffff, 16'd0, 1'b0));
    queued_items.push_back(pixel_shade(16'd0, 16'd0, 1'b0));
    queued_items.push_back(pixel_shade(16'd1, 16'd0, 1'b0));
    queued_items.push_back(pixel_shade(16'd2, 16'd0, 1'b1));
    wait_drained();

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      idle_pct = (p == CALM_PHASE) ? 0 : 18;
      random_gradient();
      random_phase();
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Sender: offers the next queued transaction, idling at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (queued_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        in_item_i  <= queued_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold that backs up the pipeline
  // while plenty of transactions are still waiting to be offered.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= HOLD_AFTER &&
                 queued_items.size() >= HOLD_BACKLOG) begin
      out_ready_i    <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: checks each output transaction against the oldest pixel due,
  // then feeds accepted input transactions to the predictor.
  always @(posedge clk_i) begin : pixel_monitor
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel, actual color %08h last %0b", $time,
                   out_item_o.pixel_color, out_item_o.span_last);
          error_count++;
        end else begin
          want = pixels_due.pop_front();
          if (out_item_o.pixel_color !== want.pixel_color) begin
            $display("%0t: pixel_color mismatch, expected %08h, actual %08h", $time,
                     want.pixel_color, out_item_o.pixel_color);
            error_count++;
          end
          if (out_item_o.span_last !== want.span_last) begin
            $display("%0t: span_last mismatch, expected %0b, actual %0b", $time,
                     want.span_last, out_item_o.span_last);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (in_item_i.func == FUNC_WRITE) begin
          ramp_colors[in_item_i.entry_index] = in_item_i.entry_color;
        end else begin
          want.pixel_color = shade_pixel(in_item_i.pixel_x, in_item_i.pixel_y);
          want.span_last   = in_item_i.span_end;
          pixels_due.push_back(want);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

endmodule
